/* hw/rtl/pps_pkg.sv */
// Shared types and codes for the preemptive priority scheduler.
`default_nettype none

package pps_pkg;

	// Field widths fixed by the request and result formats
	localparam int PID_W   = 8;
	localparam int BURST_W = 16;
	localparam int PRIO_W  = 8;
	localparam int KIND_W  = 2;
	localparam int TIME_W  = 32;

	// Request commands
	localparam logic CMD_ADMIT = 1'b0;
	localparam logic CMD_TICK  = 1'b1;

	// Result kinds
	localparam logic [KIND_W-1:0] KIND_ADMIT_OK  = 2'd0;
	localparam logic [KIND_W-1:0] KIND_ADMIT_REJ = 2'd1;
	localparam logic [KIND_W-1:0] KIND_RAN       = 2'd2;
	localparam logic [KIND_W-1:0] KIND_IDLE      = 2'd3;

	// Classified request handed from the front end to the scheduler core
	typedef struct packed {
		logic               tick;
		logic               zero_burst;
		logic [PID_W-1:0]   pid;
		logic [BURST_W-1:0] burst;
		logic [PRIO_W-1:0]  prio;
	} cmd_t;

endpackage

`default_nettype wire

/* hw/rtl/pps_front.sv */
// Front end: accepts requests, classifies them and buffers them in a two-entry queue.
`default_nettype none

module pps_front #(
	parameter int REMAINING_BITS = 16
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        req_valid,
	output logic                             req_stall,
	input  wire logic                        command,
	input  wire logic [pps_pkg::PID_W-1:0]   process_id,
	input  wire logic [pps_pkg::BURST_W-1:0] burst_time,
	input  wire logic [pps_pkg::PRIO_W-1:0]  priority_req,
	output logic                             cmd_valid,
	output pps_pkg::cmd_t                    cmd,
	input  wire logic                        cmd_pop
);

	// Largest remaining time the core counters can hold
	localparam logic [32:0] REM_MAX = (33'd1 << REMAINING_BITS) - 33'd1;

	pps_pkg::cmd_t ent_q [2];
	logic          wr_q;
	logic          rd_q;
	logic [1:0]    cnt_q;
	pps_pkg::cmd_t cls;
	logic          push;

	// Classify: flag zero bursts, saturate oversize bursts
	always_comb begin
		cls.tick       = (command == pps_pkg::CMD_TICK);
		cls.zero_burst = (burst_time == '0);
		cls.pid        = process_id;
		cls.prio       = priority_req;
		if ({17'd0, burst_time} > REM_MAX) begin
			cls.burst = REM_MAX[pps_pkg::BURST_W-1:0];
		end else begin
			cls.burst = burst_time;
		end
	end

	assign req_stall = (cnt_q == 2'd2);
	assign push      = req_valid && !req_stall;
	assign cmd_valid = (cnt_q != 2'd0);
	assign cmd       = ent_q[rd_q];

	// Queue storage
	always_ff @(posedge clk) begin
		if (push) begin
			ent_q[wr_q] <= cls;
		end
	end

	// Queue pointers and fill
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (push) begin
				wr_q <= ~wr_q;
			end
			if (cmd_pop) begin
				rd_q <= ~rd_q;
			end
			cnt_q <= cnt_q + {1'b0, push} - {1'b0, cmd_pop};
		end
	end

endmodule

`default_nettype wire

/* hw/rtl/pps_core.sv */
// Scheduler core: ready-queue cells, priority tree, compaction and result register.
`default_nettype none

module pps_core #(
	parameter int QUEUE_DEPTH    = 16,
	parameter int REMAINING_BITS = 16
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        cmd_valid,
	input  wire pps_pkg::cmd_t               cmd,
	output logic                             cmd_pop,
	output logic                             res_valid,
	input  wire logic                        res_stall,
	output logic [pps_pkg::KIND_W-1:0]       result_kind,
	output logic [pps_pkg::PID_W-1:0]        process_id_res,
	output logic [pps_pkg::BURST_W-1:0]      remaining_before,
	output logic [pps_pkg::PRIO_W-1:0]       run_priority,
	output logic                             finished,
	output logic [pps_pkg::TIME_W-1:0]       time_unit
);

	localparam int IDX_W  = $clog2(QUEUE_DEPTH);
	localparam int CNT_W  = $clog2(QUEUE_DEPTH + 1);
	localparam int LEAVES = 1 << IDX_W;
	localparam int REM_W  = REMAINING_BITS;

	// Cells
	logic [QUEUE_DEPTH-1:0]    valid_q;
	logic [pps_pkg::PID_W-1:0] pid_q  [QUEUE_DEPTH];
	logic [REM_W-1:0]          rem_q  [QUEUE_DEPTH];
	logic [pps_pkg::PRIO_W-1:0] prio_q [QUEUE_DEPTH];
	logic [CNT_W-1:0]          count_q;
	logic [pps_pkg::TIME_W-1:0] time_q;

	// Neighbour values for compaction
	logic [pps_pkg::PID_W-1:0]  up_pid  [QUEUE_DEPTH];
	logic [REM_W-1:0]           up_rem  [QUEUE_DEPTH];
	logic [pps_pkg::PRIO_W-1:0] up_prio [QUEUE_DEPTH];
	logic [QUEUE_DEPTH-1:0]     up_valid;

	// Priority tree nodes, heap order, root at 1
	logic                       n_valid [2*LEAVES];
	logic [pps_pkg::PRIO_W-1:0] n_prio  [2*LEAVES];
	logic [IDX_W-1:0]           n_idx   [2*LEAVES];
	logic [pps_pkg::PID_W-1:0]  n_pid   [2*LEAVES];
	logic [REM_W-1:0]           n_rem   [2*LEAVES];

	// Output register
	logic                        res_valid_q;
	logic [pps_pkg::KIND_W-1:0]  kind_q;
	logic [pps_pkg::PID_W-1:0]   opid_q;
	logic [pps_pkg::BURST_W-1:0] orem_q;
	logic [pps_pkg::PRIO_W-1:0]  oprio_q;
	logic                        ofin_q;
	logic [pps_pkg::TIME_W-1:0]  otime_q;

	logic             fire;
	logic             run;
	logic             done;
	logic             admit_ok;
	logic [IDX_W-1:0] best;

	assign up_valid = {1'b0, valid_q[QUEUE_DEPTH-1:1]};

	genvar gi;
	generate
		for (gi = 0; gi < QUEUE_DEPTH; gi++) begin : g_up
			if (gi < QUEUE_DEPTH - 1) begin : g_mid
				assign up_pid[gi]  = pid_q[gi+1];
				assign up_rem[gi]  = rem_q[gi+1];
				assign up_prio[gi] = prio_q[gi+1];
			end else begin : g_last
				assign up_pid[gi]  = '0;
				assign up_rem[gi]  = '0;
				assign up_prio[gi] = '0;
			end
		end

		// Unused heap slot
		assign n_valid[0] = 1'b0;
		assign n_prio[0]  = '0;
		assign n_idx[0]   = '0;
		assign n_pid[0]   = '0;
		assign n_rem[0]   = '0;

		// Leaves
		for (gi = 0; gi < LEAVES; gi++) begin : g_leaf
			if (gi < QUEUE_DEPTH) begin : g_real
				assign n_valid[LEAVES+gi] = valid_q[gi];
				assign n_prio[LEAVES+gi]  = prio_q[gi];
				assign n_pid[LEAVES+gi]   = pid_q[gi];
				assign n_rem[LEAVES+gi]   = rem_q[gi];
			end else begin : g_pad
				assign n_valid[LEAVES+gi] = 1'b0;
				assign n_prio[LEAVES+gi]  = '0;
				assign n_pid[LEAVES+gi]   = '0;
				assign n_rem[LEAVES+gi]   = '0;
			end
			assign n_idx[LEAVES+gi] = IDX_W'(gi);
		end

		// Inner nodes: right wins only with a strictly lower number, so ties keep queue order
		for (gi = 1; gi < LEAVES; gi++) begin : g_node
			logic pick_r;
			assign pick_r = n_valid[2*gi+1] &&
				(!n_valid[2*gi] || (n_prio[2*gi+1] < n_prio[2*gi]));
			assign n_valid[gi] = n_valid[2*gi] || n_valid[2*gi+1];
			assign n_prio[gi]  = pick_r ? n_prio[2*gi+1] : n_prio[2*gi];
			assign n_idx[gi]   = pick_r ? n_idx[2*gi+1]  : n_idx[2*gi];
			assign n_pid[gi]   = pick_r ? n_pid[2*gi+1]  : n_pid[2*gi];
			assign n_rem[gi]   = pick_r ? n_rem[2*gi+1]  : n_rem[2*gi];
		end
	endgenerate

	// Request handling control
	assign fire     = cmd_valid && (!res_valid_q || !res_stall);
	assign cmd_pop  = fire;
	assign best     = n_idx[1];
	assign run      = fire && cmd.tick && n_valid[1];
	assign done     = (n_rem[1] == REM_W'(1));
	assign admit_ok = fire && !cmd.tick && !cmd.zero_burst &&
		(count_q != CNT_W'(QUEUE_DEPTH));

	// Cell payload: append, decrement, or move up behind a finished entry
	always_ff @(posedge clk) begin
		for (int i = 0; i < QUEUE_DEPTH; i++) begin
			if (admit_ok && (count_q == CNT_W'(i))) begin
				pid_q[i]  <= cmd.pid;
				rem_q[i]  <= REM_W'(cmd.burst);
				prio_q[i] <= cmd.prio;
			end else if (run && done && (IDX_W'(i) >= best)) begin
				pid_q[i]  <= up_pid[i];
				rem_q[i]  <= up_rem[i];
				prio_q[i] <= up_prio[i];
			end else if (run && (IDX_W'(i) == best)) begin
				rem_q[i] <= rem_q[i] - REM_W'(1);
			end
		end
	end

	// Valid bits, fill and time
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= '0;
			count_q <= '0;
			time_q  <= '0;
		end else begin
			if (admit_ok) begin
				valid_q[count_q[IDX_W-1:0]] <= 1'b1;
				count_q <= count_q + CNT_W'(1);
			end else if (run && done) begin
				for (int i = 0; i < QUEUE_DEPTH; i++) begin
					if (IDX_W'(i) >= best) begin
						valid_q[i] <= up_valid[i];
					end
				end
				count_q <= count_q - CNT_W'(1);
			end
			if (fire && cmd.tick) begin
				time_q <= time_q + 32'd1;
			end
		end
	end

	// Result payload
	always_ff @(posedge clk) begin
		if (fire) begin
			otime_q <= time_q;
			if (!cmd.tick) begin
				kind_q  <= admit_ok ? pps_pkg::KIND_ADMIT_OK : pps_pkg::KIND_ADMIT_REJ;
				opid_q  <= cmd.pid;
				orem_q  <= '0;
				oprio_q <= '0;
				ofin_q  <= 1'b0;
			end else if (n_valid[1]) begin
				kind_q  <= pps_pkg::KIND_RAN;
				opid_q  <= n_pid[1];
				orem_q  <= pps_pkg::BURST_W'(n_rem[1]);
				oprio_q <= n_prio[1];
				ofin_q  <= done;
			end else begin
				kind_q  <= pps_pkg::KIND_IDLE;
				opid_q  <= '0;
				orem_q  <= '0;
				oprio_q <= '0;
				ofin_q  <= 1'b0;
			end
		end
	end

	// Result valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (fire) begin
			res_valid_q <= 1'b1;
		end else if (!res_stall) begin
			res_valid_q <= 1'b0;
		end
	end

	assign res_valid        = res_valid_q;
	assign result_kind      = kind_q;
	assign process_id_res   = opid_q;
	assign remaining_before = orem_q;
	assign run_priority     = oprio_q;
	assign finished         = ofin_q;
	assign time_unit        = otime_q;

`ifndef SYNTHESIS
	a_count_range: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(QUEUE_DEPTH))
		else $error("ready queue fill beyond depth");

	a_valid_matches_count: assert property (@(posedge clk) disable iff (!arst_n)
		$countones(valid_q) == int'(count_q))
		else $error("valid cells disagree with fill");

	a_admit_grows: assert property (@(posedge clk) disable iff (!arst_n)
		admit_ok |=> count_q == $past(count_q) + CNT_W'(1))
		else $error("accepted admit did not grow the queue");

	a_tick_time: assert property (@(posedge clk) disable iff (!arst_n)
		(fire && cmd.tick) |=> time_q == $past(time_q) + 32'd1)
		else $error("tick did not advance time");

	a_finish_shrinks: assert property (@(posedge clk) disable iff (!arst_n)
		(run && done) |=> count_q == $past(count_q) - CNT_W'(1))
		else $error("finished entry not removed");
`endif

endmodule

`default_nettype wire

/* hw/rtl/preemptive_priority_scheduler.sv */
// Top level of the preemptive priority scheduler.
// A request either admits a process (id, burst, priority) at the tail of a ready queue of
// QUEUE_DEPTH entries or runs one time unit; every request yields exactly one result. A tick
// runs the entry with the lowest priority number, the earliest-queued one on a tie, reports
// its remaining time before the unit and removes it when that reaches zero; an empty queue
// reports idle and time still advances. Zero bursts and admits to a full queue are rejected.
// One request is taken per cycle sustained while res_stall is low; an accepted request is
// written into a two-entry request queue; the core then handles it and loads its result
// into the result register. The priority tree over the queue cells is combinational, and
// the core selects, decrements and compacts in the same cycle. No clearing pass is needed
// after reset.
`default_nettype none

module preemptive_priority_scheduler #(
	parameter int QUEUE_DEPTH    = 16,
	parameter int REMAINING_BITS = 16
) (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        req_valid,
	output logic                             req_stall,
	input  wire logic                        command,
	input  wire logic [pps_pkg::PID_W-1:0]   process_id,
	input  wire logic [pps_pkg::BURST_W-1:0] burst_time,
	input  wire logic [pps_pkg::PRIO_W-1:0]  priority_req,
	output logic                             res_valid,
	input  wire logic                        res_stall,
	output logic [pps_pkg::KIND_W-1:0]       result_kind,
	output logic [pps_pkg::PID_W-1:0]        process_id_res,
	output logic [pps_pkg::BURST_W-1:0]      remaining_before,
	output logic [pps_pkg::PRIO_W-1:0]       run_priority,
	output logic                             finished,
	output logic [pps_pkg::TIME_W-1:0]       time_unit
);

	logic          cmd_valid;
	logic          cmd_pop;
	pps_pkg::cmd_t cmd;

	// Request classification and buffering
	pps_front #(
		.REMAINING_BITS(REMAINING_BITS)
	) u_front (
		.clk         (clk),
		.arst_n      (arst_n),
		.req_valid   (req_valid),
		.req_stall   (req_stall),
		.command     (command),
		.process_id  (process_id),
		.burst_time  (burst_time),
		.priority_req(priority_req),
		.cmd_valid   (cmd_valid),
		.cmd         (cmd),
		.cmd_pop     (cmd_pop)
	);

	// Scheduling and results
	pps_core #(
		.QUEUE_DEPTH   (QUEUE_DEPTH),
		.REMAINING_BITS(REMAINING_BITS)
	) u_core (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd_valid       (cmd_valid),
		.cmd             (cmd),
		.cmd_pop         (cmd_pop),
		.res_valid       (res_valid),
		.res_stall       (res_stall),
		.result_kind     (result_kind),
		.process_id_res  (process_id_res),
		.remaining_before(remaining_before),
		.run_priority    (run_priority),
		.finished        (finished),
		.time_unit       (time_unit)
	);

endmodule

`default_nettype wire
